[rtl/aacr_pkg.sv]
package aacr_pkg;

    // internal position width: 32-bit coordinates plus headroom for
    // half extents, half unit and skin added on top
    localparam int POS_W = 36;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [20:0]             ext_t;
    typedef logic [15:0]             skin_t;
    typedef logic [1:0]              cmd_t;
    typedef logic [2:0]              reg_idx_t;
    typedef logic [1:0]              pass_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } cent_t;

    typedef struct packed {
        logic  enable;
        ext_t  hx;
        ext_t  hy;
        ext_t  hz;
        skin_t skin;
    } cfg_t;

    typedef struct packed {
        pos_t push;
        logic hit;
        logic land;
        pos_t bmaxy;
    } step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH,
        ST_HOLD
    } state_t;

    localparam cmd_t CMD_CLEAR   = 2'd0;
    localparam cmd_t CMD_ADD     = 2'd1;
    localparam cmd_t CMD_RESOLVE = 2'd2;

    localparam reg_idx_t REG_ENABLE = 3'd0;
    localparam reg_idx_t REG_HX     = 3'd1;
    localparam reg_idx_t REG_HY     = 3'd2;
    localparam reg_idx_t REG_HZ     = 3'd3;
    localparam reg_idx_t REG_SKIN   = 3'd4;

    localparam pass_t PASS_X   = 2'd0;
    localparam pass_t PASS_Y   = 2'd1;
    localparam pass_t PASS_Z   = 2'd2;
    localparam pass_t PASS_GND = 2'd3;

    localparam pos_t POS_MAX = 36'sd2147483647;
    localparam pos_t POS_MIN = -36'sd2147483648;

    function automatic pos_t sx32(input logic [31:0] v);
        return {{(POS_W-32){v[31]}}, v};
    endfunction

    function automatic pos_t zx_ext(input ext_t v);
        return {{(POS_W-21){1'b0}}, v};
    endfunction

    function automatic pos_t zx_skin(input skin_t v);
        return {{(POS_W-16){1'b0}}, v};
    endfunction

    function automatic logic [31:0] sat32(input pos_t v);
        logic [31:0] r;
        if (v > POS_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < POS_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/aacr_cell.sv]
// one slot of the rotating block ring
module aacr_cell
    import aacr_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  logic  load,
    input  cent_t shift_in,
    input  cent_t load_data,
    output cent_t q
);

    cent_t q_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            q_reg <= load_data;
        else if (shift)
            q_reg <= shift_in;
    end

    assign q = q_reg;

endmodule

[rtl/aacr_step.sv]
// per-block test against the head of the ring: push-out and ground landing
module aacr_step
    import aacr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  pos_t  p [3],
    input  cent_t c,
    input  pass_t axis,
    input  logic  vpos,
    input  pos_t  first_y,
    input  cfg_t  cfg,
    output step_t res
);

    localparam pos_t HALF = pos_t'(64'd1 << (FRAC_BITS - 1));

    pos_t ce [3];
    pos_t h  [3];
    pos_t lo [3];
    pos_t hi [3];
    logic [2:0] ov;
    logic [2:0] span;
    pos_t skin;
    pos_t before_y;
    pos_t after_y;

    always_comb
    begin
        ce[0] = sx32(c.x);
        ce[1] = sx32(c.y);
        ce[2] = sx32(c.z);
        h[0]  = zx_ext(cfg.hx);
        h[1]  = zx_ext(cfg.hy);
        h[2]  = zx_ext(cfg.hz);
        skin  = zx_skin(cfg.skin);
        for (int a = 0; a < 3; a++)
        begin
            lo[a]   = ce[a] - HALF;
            hi[a]   = ce[a] + HALF;
            ov[a]   = (p[a] - h[a] < hi[a]) && (p[a] + h[a] > lo[a]);
            span[a] = !((p[a] + h[a] < lo[a]) || (p[a] - h[a] > hi[a]));
        end
        res.hit = &ov;

        unique case (axis)
            PASS_X:  res.push = vpos ? lo[0] - h[0] - skin : hi[0] + h[0] + skin;
            PASS_Y:  res.push = vpos ? lo[1] - h[1] - skin : hi[1] + h[1] + skin;
            PASS_Z:  res.push = vpos ? lo[2] - h[2] - skin : hi[2] + h[2] + skin;
            default: res.push = p[0];
        endcase

        before_y  = first_y - h[1];
        after_y   = p[1] - h[1];
        res.bmaxy = hi[1];
        res.land  = span[0] && span[2]
                    && (before_y >= hi[1] - skin) && (after_y <= hi[1] + skin);
    end

endmodule

[rtl/aabb_axis_collision_resolver_core.sv]
// Channel | Dir  | Handshake            | Payload
// cmd     | in   | cmd_valid/cmd_stall  | command, first_x/y/z, want_x/y/z
// res     | out  | res_valid/res_stall  | out_x/y/z, on_ground, list_full
// cfg     | in   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A clear only resets the block count and gives no result. An add, and a
// disabled or tiny move, pass through the hold state, where the result is
// registered once the output is free. A resolve rotates the block ring once
// per active pass (x, y, z, ground), then goes through finish and hold.
// Passes with zero motion on their axis are skipped, ground only on falling.
// Reset clears count, state and res_valid and loads the config defaults; block slots are left as they are.
// cmd_stall is high while a move is in flight or its result is not yet
// registered; a waiting result holds back only the registering of the next.
module aabb_axis_collision_resolver_core
    import aacr_pkg::*;
#(
    parameter int MAX_BLOCKS = 256,
    parameter int FRAC_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [31:0] first_x,
    input  logic [31:0] first_y,
    input  logic [31:0] first_z,
    input  logic [31:0] want_x,
    input  logic [31:0] want_y,
    input  logic [31:0] want_z,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        on_ground,
    output logic        list_full,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    localparam int KW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    // squared-motion threshold, round(1e-8 * 2^(2*FRAC_BITS))
    localparam longint unsigned THR =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd50000000) / 64'd100000000;

    // configuration
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b1;
            cfg_reg.hx     <= 21'd16384;
            cfg_reg.hy     <= 21'd65536;
            cfg_reg.hz     <= 21'd16384;
            cfg_reg.skin   <= 16'd66;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                REG_HX:     cfg_reg.hx     <= cfg_data;
                REG_HY:     cfg_reg.hy     <= cfg_data;
                REG_HZ:     cfg_reg.hz     <= cfg_data;
                REG_SKIN:   cfg_reg.skin   <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    // control and datapath registers
    state_t          state_reg, state_next;
    pass_t           pass_reg, pass_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            res_valid_reg, res_valid_next;

    pos_t            p_reg [3];
    pos_t            p_next [3];
    pos_t            want_reg [3];
    pos_t            want_next [3];
    pos_t            first_y_reg, first_y_next;
    logic [2:0]      vnz_reg, vnz_next;
    logic [2:0]      vpos_reg, vpos_next;
    logic            vneg_y_reg, vneg_y_next;
    logic            found_reg, found_next;
    pos_t            top_reg, top_next;
    logic            ground_reg, ground_next;
    logic            full_reg, full_next;
    logic [31:0]     ox_reg, oy_reg, oz_reg;
    logic [31:0]     ox_next, oy_next, oz_next;
    logic            og_reg, og_next, olf_reg, olf_next;

    // block ring: slot 0 is the head the step unit looks at
    cent_t           ring [MAX_BLOCKS];
    logic            ring_shift;
    logic            add_en;
    cent_t           add_data;

    assign add_data = '{x: first_x, y: first_y, z: first_z};

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_ring
        aacr_cell u_cell (
            .clk       (clk),
            .shift     (ring_shift),
            .load      (add_en && (count_reg == CW'(i))),
            .shift_in  (ring[(i + 1) % MAX_BLOCKS]),
            .load_data (add_data),
            .q         (ring[i])
        );
    end

    step_t step;

    aacr_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .p       (p_reg),
        .c       (ring[0]),
        .axis    (pass_reg),
        .vpos    (vpos_reg[pass_reg == PASS_GND ? 2'd0 : pass_reg]),
        .first_y (first_y_reg),
        .cfg     (cfg_reg),
        .res     (step)
    );

    // motion check at command time
    logic signed [32:0] vel [3];
    logic [32:0]        mag [3];
    logic [23:0]        sq [3];
    logic [25:0]        sq_sum;
    logic               small_motion;
    logic               cmd_accept;
    logic               slot_active;
    logic               out_free;

    always_comb
    begin
        vel[0] = {want_x[31], want_x} - {first_x[31], first_x};
        vel[1] = {want_y[31], want_y} - {first_y[31], first_y};
        vel[2] = {want_z[31], want_z} - {first_z[31], first_z};
        small_motion = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            mag[a] = vel[a][32] ? 33'(-vel[a]) : 33'(vel[a]);
            sq[a]  = mag[a][11:0] * mag[a][11:0];
            if (mag[a][32:12] != '0)
                small_motion = 1'b0;
        end
        sq_sum = 26'(sq[0]) + 26'(sq[1]) + 26'(sq[2]);
        if ({38'd0, sq_sum} >= THR)
            small_motion = 1'b0;
    end

    // first pass at or after a given one that has work to do; bit 2 flags none
    function automatic logic [2:0] pick_pass(input logic [2:0] from, input logic [2:0] vnz,
                                             input logic vneg_y);
        logic [2:0] r;
        r = 3'b100;
        for (int i = 3; i >= 0; i--)
        begin
            if ((3'(i) >= from) && ((i < 3) ? vnz[i] : vneg_y))
                r = 3'(i);
        end
        return r;
    endfunction

    logic [2:0] nxt;

    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign cmd_stall   = (state_reg != ST_IDLE);
    assign slot_active = CW'(k_reg) < count_reg;
    assign out_free    = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        p_next         = p_reg;
        want_next      = want_reg;
        first_y_next   = first_y_reg;
        vnz_next       = vnz_reg;
        vpos_next      = vpos_reg;
        vneg_y_next    = vneg_y_reg;
        found_next     = found_reg;
        top_next       = top_reg;
        ground_next    = ground_reg;
        full_next      = full_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oz_next        = oz_reg;
        og_next        = og_reg;
        olf_next       = olf_reg;
        ring_shift     = 1'b0;
        add_en         = 1'b0;
        nxt            = 3'b100;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    unique case (command)
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_ADD:
                        begin
                            full_next = (count_reg == CW'(MAX_BLOCKS));
                            if (count_reg != CW'(MAX_BLOCKS))
                            begin
                                add_en     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            for (int a = 0; a < 3; a++)
                                p_next[a] = '0;
                            ground_next = 1'b0;
                            state_next  = ST_HOLD;
                        end
                        CMD_RESOLVE:
                        begin
                            full_next    = 1'b0;
                            ground_next  = 1'b0;
                            found_next   = 1'b0;
                            want_next[0] = sx32(want_x);
                            want_next[1] = sx32(want_y);
                            want_next[2] = sx32(want_z);
                            first_y_next = sx32(first_y);
                            for (int a = 0; a < 3; a++)
                            begin
                                vnz_next[a]  = (vel[a] != '0);
                                vpos_next[a] = !vel[a][32] && (vel[a] != '0);
                            end
                            vneg_y_next = vel[1][32];
                            if (!cfg_reg.enable || small_motion)
                            begin
                                p_next     = want_next;
                                state_next = ST_HOLD;
                            end
                            else
                            begin
                                p_next[0] = sx32(first_x);
                                p_next[1] = sx32(first_y);
                                p_next[2] = sx32(first_z);
                                nxt = pick_pass(3'd0, vnz_next, vneg_y_next);
                                if (nxt[2])
                                    state_next = ST_FINISH;
                                else
                                begin
                                    pass_next = nxt[1:0];
                                    // entering an axis pass: p moves to the desired coordinate
                                    if (nxt[1:0] != PASS_GND)
                                        p_next[nxt[1:0]] = want_next[nxt[1:0]];
                                    k_next     = '0;
                                    state_next = ST_SWEEP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SWEEP:
            begin
                ring_shift = 1'b1;
                if (slot_active)
                begin
                    if (pass_reg == PASS_GND)
                    begin
                        if (step.land)
                        begin
                            if (!found_reg || step.bmaxy > top_reg)
                                top_next = step.bmaxy;
                            found_next = 1'b1;
                        end
                    end
                    else if (step.hit)
                        p_next[pass_reg] = step.push;
                end
                if (k_reg == KW'(MAX_BLOCKS - 1))
                begin
                    // ring is back in list order
                    k_next = '0;
                    nxt = pick_pass(3'(pass_reg) + 3'd1, vnz_reg, vneg_y_reg);
                    if (nxt[2])
                        state_next = ST_FINISH;
                    else
                    begin
                        pass_next = nxt[1:0];
                        if (nxt[1:0] != PASS_GND)
                            p_next[nxt[1:0]] = want_reg[nxt[1:0]];
                    end
                end
                else
                    k_next = k_reg + 1'b1;
            end

            ST_FINISH:
            begin
                if (found_reg)
                begin
                    p_next[1]   = top_reg + zx_ext(cfg_reg.hy) + zx_skin(cfg_reg.skin);
                    ground_next = 1'b1;
                end
                if (vneg_y_reg && (p_next[1] - want_reg[1] > zx_skin(cfg_reg.skin)))
                    ground_next = 1'b1;
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    ox_next        = sat32(p_reg[0]);
                    oy_next        = sat32(p_reg[1]);
                    oz_next        = sat32(p_reg[2]);
                    og_next        = ground_reg;
                    olf_next       = full_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_X;
            k_reg         <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        want_reg    <= want_next;
        first_y_reg <= first_y_next;
        vnz_reg     <= vnz_next;
        vpos_reg    <= vpos_next;
        vneg_y_reg  <= vneg_y_next;
        found_reg   <= found_next;
        top_reg     <= top_next;
        ground_reg  <= ground_next;
        full_reg    <= full_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oz_reg      <= oz_next;
        og_reg      <= og_next;
        olf_reg     <= olf_next;
    end

    assign res_valid = res_valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign on_ground = og_reg;
    assign list_full = olf_reg;

    // ring must sit in list order whenever it is not rotating
    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SWEEP) |-> (k_reg == '0))
        else $error("ring left rotated outside a sweep");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count beyond capacity");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (command == CMD_ADD) && (count_reg != CW'(MAX_BLOCKS)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted add did not grow the list");

    a_full_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && list_full) |-> (out_x == '0 && out_y == '0 && on_ground == 1'b0))
        else $error("dropped add carries position data");

endmodule
